/* hw/rtl/rthc_pkg.sv */
package rthc_pkg;

  // Channel and result widths.
  localparam int unsigned CH_W    = 8;
  localparam int unsigned HUE_W   = 15;
  localparam int unsigned Q15_W   = 16;
  // Quotient bits produced by each long-division pipeline.
  localparam int unsigned QUO_W   = 16;
  // Dividend width seen by the dividers.
  localparam int unsigned DVD_W   = CH_W + QUO_W;
  // Signed width of the hue numerator before scaling.
  localparam int unsigned TOP_W   = 19;

  localparam logic [8:0] HUE_STEP_DEG  = 9'd60;
  localparam logic [8:0] HUE_RED_WRAP  = 9'd360;
  localparam logic [8:0] HUE_GREEN_OFS = 9'd120;
  localparam logic [8:0] HUE_BLUE_OFS  = 9'd240;
  localparam logic [8:0] HUE_RED_OFS   = 9'd0;

  // Which hexcone sector the pixel falls in; selects the hue offset.
  typedef enum logic [1:0] {
    SECT_RED_UP   = 2'd0,
    SECT_RED_WRAP = 2'd1,
    SECT_GREEN    = 2'd2,
    SECT_BLUE     = 2'd3
  } hue_sect_e;

  // Work handed from the front end to the dividers.
  typedef struct packed {
    logic [DVD_W-1:0] hue_num;
    logic [CH_W-1:0]  hue_den;
    logic [DVD_W-1:0] sat_num;
    logic [CH_W-1:0]  sat_den;
    logic [Q15_W-1:0] bri;
  } div_job_t;

endpackage

/* hw/rtl/rgb_to_hsv_converter_unit.sv */
// RGB to HSV converter: one 8-bit RGB pixel in, hue, saturation, brightness out.
// It has 2 front-end stages and 16 long-division stages; throughput is one pixel
// per cycle while the output is not stalled.
// The two 16-stage division pipelines each produce one quotient bit per stage.
// Reset (rst_ni low, asynchronous) clears only the stage valid bits.
module rgb_to_hsv_converter_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // Fields from bit 0 up: red [7:0], green [15:8], blue [23:16].
  input  logic [23:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // Fields from bit 0 up: hue [14:0], saturation [30:15], brightness [46:31],
  // bit 47 is zero.
  output logic [47:0] m_axis_tdata_o
);
  import rthc_pkg::*;

  // Two front-end stages followed by one stage per quotient bit.
  localparam int unsigned NSTG = 2 + QUO_W;

  // Each stage carries a valid bit. A stage may load when it is empty or
  // when its own contents move on in the same cycle, so bubbles collapse
  // and a stalled output still lets new requests fill the empty stages.
  // A stage is held only when it and every stage after it are full and
  // the output is not taken.
  logic [NSTG-1:0] vld_q;
  logic [NSTG-1:0] en;
  logic            stall;

  always_comb begin
    stall      = vld_q[NSTG-1] && !m_axis_tready_i;
    en[NSTG-1] = !stall;
    for (int i = NSTG - 2; i >= 0; i--) begin
      stall = stall && vld_q[i];
      en[i] = !stall;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= s_axis_tvalid_i;
      end
      for (int i = 1; i < NSTG; i++) begin
        if (en[i]) begin
          vld_q[i] <= vld_q[i-1];
        end
      end
    end
  end

  assign s_axis_tready_o = en[0];
  assign m_axis_tvalid_o = vld_q[NSTG-1];

  // Front end: channel max/min, sector and the operands for both divisions.
  div_job_t job;

  rthc_prep u_prep (
    .clk_i   (clk_i),
    .en_i    (en[1:0]),
    .red_i   (s_axis_tdata_i[7:0]),
    .green_i (s_axis_tdata_i[15:8]),
    .blue_i  (s_axis_tdata_i[23:16]),
    .job_o   (job)
  );

  // Hue: 64 * (60 * diff + offset * delta) / delta.
  logic [QUO_W-1:0] hue_quo;

  rthc_div #(.QW(QUO_W)) u_hue_div (
    .clk_i      (clk_i),
    .en_i       (en[NSTG-1:2]),
    .dividend_i (job.hue_num),
    .divisor_i  (job.hue_den),
    .quotient_o (hue_quo)
  );

  // Saturation: 32768 * delta / max.
  logic [QUO_W-1:0] sat_quo;

  rthc_div #(.QW(QUO_W)) u_sat_div (
    .clk_i      (clk_i),
    .en_i       (en[NSTG-1:2]),
    .dividend_i (job.sat_num),
    .divisor_i  (job.sat_den),
    .quotient_o (sat_quo)
  );

  // Brightness is ready after the front end; it rides along a delay line
  // that steps with the division stages.
  logic [Q15_W-1:0] bri_q [QUO_W];

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      bri_q[0] <= job.bri;
    end
    for (int k = 1; k < QUO_W; k++) begin
      if (en[2+k]) begin
        bri_q[k] <= bri_q[k-1];
      end
    end
  end

  assign m_axis_tdata_o = {1'b0, bri_q[QUO_W-1], sat_quo[Q15_W-1:0], hue_quo[HUE_W-1:0]};

endmodule

/* hw/rtl/rthc_prep.sv */
module rthc_prep (
  input  logic                           clk_i,
  input  logic [1:0]                     en_i,
  input  logic [rthc_pkg::CH_W-1:0]      red_i,
  input  logic [rthc_pkg::CH_W-1:0]      green_i,
  input  logic [rthc_pkg::CH_W-1:0]      blue_i,
  output rthc_pkg::div_job_t             job_o
);
  import rthc_pkg::*;

  // First stage: max, min, sector and signed channel difference.
  logic [CH_W-1:0] mx_d, mx_q, dlt_d, dlt_q;
  logic [CH_W-1:0] mn;
  logic signed [8:0] num_d, num_q;
  hue_sect_e sect_d, sect_q;
  logic [1:0] imax;

  always_comb begin
    imax = 2'd0;
    mx_d = red_i;
    if (green_i > mx_d) begin
      imax = 2'd1;
      mx_d = green_i;
    end
    if (blue_i > mx_d) begin
      imax = 2'd2;
      mx_d = blue_i;
    end
    mn = red_i;
    if (green_i < mn) begin
      mn = green_i;
    end
    if (blue_i < mn) begin
      mn = blue_i;
    end
    dlt_d = mx_d - mn;
    case (imax)
      2'd1: begin
        sect_d = SECT_GREEN;
        num_d  = $signed({1'b0, blue_i}) - $signed({1'b0, red_i});
      end
      2'd2: begin
        sect_d = SECT_BLUE;
        num_d  = $signed({1'b0, red_i}) - $signed({1'b0, green_i});
      end
      default: begin
        sect_d = (green_i >= blue_i) ? SECT_RED_UP : SECT_RED_WRAP;
        num_d  = $signed({1'b0, green_i}) - $signed({1'b0, blue_i});
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      mx_q   <= mx_d;
      dlt_q  <= dlt_d;
      num_q  <= num_d;
      sect_q <= sect_d;
    end
  end

  // Second stage: hue numerator, divisors and brightness.
  logic [8:0]             ofs_val;
  logic signed [TOP_W-1:0] num_ext, ofs_ext, dlt_ext, top_s;
  logic [14:0]            bri_x;
  logic [15:0]            bri_fix;
  div_job_t               job_d, job_q;

  always_comb begin
    case (sect_q)
      SECT_RED_WRAP: ofs_val = HUE_RED_WRAP;
      SECT_GREEN:    ofs_val = HUE_GREEN_OFS;
      SECT_BLUE:     ofs_val = HUE_BLUE_OFS;
      default:       ofs_val = HUE_RED_OFS;
    endcase
    num_ext = {{(TOP_W-9){num_q[8]}}, num_q};
    ofs_ext = $signed({{(TOP_W-9){1'b0}}, ofs_val});
    dlt_ext = $signed({{(TOP_W-CH_W){1'b0}}, dlt_q});
    top_s   = num_ext * $signed({{(TOP_W-9){1'b0}}, HUE_STEP_DEG}) + ofs_ext * dlt_ext;

    job_d.hue_num = {1'b0, top_s[16:0], 6'b000000};
    job_d.hue_den = (dlt_q == '0) ? CH_W'(1) : dlt_q;
    job_d.sat_num = {1'b0, dlt_q, 15'd0};
    job_d.sat_den = (mx_q == '0) ? CH_W'(1) : mx_q;

    // max * 32768 / 255 = max * 128 + floor(max * 128 / 255).
    bri_x     = {mx_q, 7'd0};
    bri_fix   = ({1'b0, bri_x} + 16'd1 + {9'd0, bri_x[14:8]}) >> 8;
    job_d.bri = {1'b0, bri_x} + bri_fix;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      job_q <= job_d;
    end
  end

  assign job_o = job_q;

endmodule

/* hw/rtl/rthc_div.sv */
module rthc_div #(
  parameter int unsigned QW = 16
) (
  input  logic                                clk_i,
  input  logic [QW-1:0]                       en_i,
  input  logic [rthc_pkg::CH_W+QW-1:0]        dividend_i,
  input  logic [rthc_pkg::CH_W-1:0]           divisor_i,
  output logic [QW-1:0]                       quotient_o
);
  import rthc_pkg::*;

  // Restoring long division, one quotient bit per register stage.
  // The quotient must fit in QW bits, so the upper dividend bits are
  // already a valid partial remainder.
  logic [CH_W-1:0] rem_q [QW];
  logic [QW-1:0]   low_q [QW];
  logic [QW-1:0]   quo_q [QW];
  logic [CH_W-1:0] dvs_q [QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [CH_W-1:0] rem_src, dvs_src, rem_d;
    logic [QW-1:0]   low_src, quo_src, low_d, quo_d;
    logic [CH_W:0]   trial;
    logic            ge;

    if (s == 0) begin : g_first
      assign rem_src = dividend_i[CH_W+QW-1:QW];
      assign low_src = dividend_i[QW-1:0];
      assign quo_src = '0;
      assign dvs_src = divisor_i;
    end else begin : g_next
      assign rem_src = rem_q[s-1];
      assign low_src = low_q[s-1];
      assign quo_src = quo_q[s-1];
      assign dvs_src = dvs_q[s-1];
    end

    always_comb begin
      trial = {rem_src, low_src[QW-1]};
      ge    = (trial >= {1'b0, dvs_src});
      rem_d = ge ? CH_W'(trial - {1'b0, dvs_src}) : trial[CH_W-1:0];
      low_d = {low_src[QW-2:0], 1'b0};
      quo_d = {quo_src[QW-2:0], ge};
    end

    always_ff @(posedge clk_i) begin
      if (en_i[s]) begin
        rem_q[s] <= rem_d;
        low_q[s] <= low_d;
        quo_q[s] <= quo_d;
        dvs_q[s] <= dvs_src;
      end
    end
  end

  assign quotient_o = quo_q[QW-1];

endmodule

/* test/tb_rgb_to_hsv_converter_unit.sv */
`timescale 1ns / 1ps

module tb_rgb_to_hsv_converter_unit;
  import rthc_pkg::*;

  // The drain wait is well beyond the pipeline depth, so it is enough to catch
  // any stray result after the last expected one.
  localparam int DRAIN_CYCLES = 40;
  localparam int RAND_PIXELS  = 750;

  typedef struct {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pixel_t;

  typedef struct {
    logic [HUE_W-1:0] hue;
    logic [Q15_W-1:0] sat;
    logic [Q15_W-1:0] bri;
  } hsv_t;

  logic        clk_i   = 1'b0;
  logic        rst_ni  = 1'b0;
  logic        s_valid = 1'b0;
  logic [23:0] s_data  = '0;
  logic        s_ready;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [47:0] m_data;

  // Pixels still to be sent, and the HSV triples the design owes us, oldest first.
  pixel_t pixel_q[$];
  hsv_t   hsv_owed_q[$];

  int   total_pixels  = 0;
  int   directed_cnt  = 0;
  int   accepted_cnt  = 0;
  int   error_cnt     = 0;
  logic req_fire      = 1'b0;

  rgb_to_hsv_converter_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Hexcone conversion, computed exactly and then floored to each grid. Ties
  // for the largest or smallest channel go to red, then green, then blue.
  function automatic hsv_t rgb_to_hsv(pixel_t px);
    int        chan [3];
    int        hi_idx;
    int        lo_idx;
    int        peak;
    int        span;
    int        num;
    int        ofs;
    int        top;
    int        hue_v;
    int        sat_v;
    int        bri_v;
    hue_sect_e sect;
    hsv_t      res;
    chan[0] = px.red;
    chan[1] = px.green;
    chan[2] = px.blue;
    hi_idx  = 0;
    lo_idx  = 0;
    for (int k = 1; k < 3; k++) begin
      if (chan[k] > chan[hi_idx]) hi_idx = k;
      if (chan[k] < chan[lo_idx]) lo_idx = k;
    end
    peak  = chan[hi_idx];
    span  = peak - chan[lo_idx];
    hue_v = 0;
    // A grey pixel (all channels equal) has no defined hue and reports zero.
    if (span != 0) begin
      if (hi_idx == 0) begin
        sect = (px.green >= px.blue) ? SECT_RED_UP : SECT_RED_WRAP;
      end else if (hi_idx == 1) begin
        sect = SECT_GREEN;
      end else begin
        sect = SECT_BLUE;
      end
      case (sect)
        SECT_RED_UP: begin
          num = chan[1] - chan[2];
          ofs = int'(HUE_RED_OFS);
        end
        SECT_RED_WRAP: begin
          num = chan[1] - chan[2];
          ofs = int'(HUE_RED_WRAP);
        end
        SECT_GREEN: begin
          num = chan[2] - chan[0];
          ofs = int'(HUE_GREEN_OFS);
        end
        default: begin
          num = chan[0] - chan[1];
          ofs = int'(HUE_BLUE_OFS);
        end
      endcase
      top = int'(HUE_STEP_DEG) * num + ofs * span;
      if (top < 0) top = 0;
      hue_v = (top * 64) / span;
    end
    // A black pixel has no defined saturation and reports zero.
    sat_v   = (peak != 0) ? (span * 32768) / peak : 0;
    bri_v   = (peak * 32768) / 255;
    res.hue = hue_v[HUE_W-1:0];
    res.sat = sat_v[Q15_W-1:0];
    res.bri = bri_v[Q15_W-1:0];
    return res;
  endfunction

  // Idle percentage for either side. The run is split in thirds by the number
  // of accepted requests: a slow receiver first, then a slow sender, then
  // both sides at full rate.
  function automatic int idle_pct(bit receiver);
    if (accepted_cnt < total_pixels / 3) return receiver ? 57 : 19;
    if (accepted_cnt < (2 * total_pixels) / 3) return receiver ? 19 : 57;
    return 0;
  endfunction

  // The sender stops twice, at the end of the directed pixels and halfway
  // through the random ones, until the pipeline has fully drained.
  function automatic bit drain_hold();
    return (accepted_cnt == directed_cnt ||
            accepted_cnt == directed_cnt + RAND_PIXELS / 2) &&
           hsv_owed_q.size() != 0;
  endfunction

  task automatic add_pixel(int r, int g, int b);
    pixel_t px;
    px.red   = r[CH_W-1:0];
    px.green = g[CH_W-1:0];
    px.blue  = b[CH_W-1:0];
    pixel_q.push_back(px);
  endtask

  task automatic check_field(string name, int expected, int actual);
    if (expected != actual) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, expected, actual);
      error_cnt++;
    end
  endtask

  // Driver: inputs move only on the falling edge. A new request is offered
  // once the slot is free, i.e. nothing is held or the last one was taken.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_valid || req_fire) begin
        if (pixel_q.size() != 0 && !drain_hold() && $urandom_range(99) >= idle_pct(1'b0)) begin
          s_data  <= {pixel_q[0].blue, pixel_q[0].green, pixel_q[0].red};
          s_valid <= 1'b1;
          pixel_q.pop_front();
        end else begin
          s_valid <= 1'b0;
        end
      end
      m_ready <= ($urandom_range(99) >= idle_pct(1'b1));
    end
  end

  // Monitor: both handshakes are sampled on the rising edge. Results are
  // checked before the new request is queued, so a result can never be
  // matched against the pixel that entered in the same cycle.
  always @(posedge clk_i) begin
    pixel_t px;
    if (rst_ni) begin
      if (m_valid && m_ready) begin
        if (hsv_owed_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual 0x%012h", $time, m_data);
          error_cnt++;
        end else begin
          check_field("hue", hsv_owed_q[0].hue, m_data[14:0]);
          check_field("saturation", hsv_owed_q[0].sat, m_data[30:15]);
          check_field("brightness", hsv_owed_q[0].bri, m_data[46:31]);
          hsv_owed_q.pop_front();
        end
      end
      req_fire <= s_valid && s_ready;
      if (s_valid && s_ready) begin
        px.red   = s_data[7:0];
        px.green = s_data[15:8];
        px.blue  = s_data[23:16];
        hsv_owed_q.push_back(rgb_to_hsv(px));
        accepted_cnt <= accepted_cnt + 1;
      end
    end
  end

  initial begin
    int r;
    int g;
    int b;
    // Directed pixels: black, white, the primaries, the two-way ties for the
    // largest channel, grey, both sides of the red wrap, single-bit values
    // and near-extreme cases.
    add_pixel(0, 0, 0);
    add_pixel(255, 255, 255);
    add_pixel(255, 0, 0);
    add_pixel(0, 255, 0);
    add_pixel(0, 0, 255);
    add_pixel(255, 255, 0);
    add_pixel(255, 0, 255);
    add_pixel(0, 255, 255);
    add_pixel(128, 128, 128);
    add_pixel(255, 0, 1);
    add_pixel(255, 1, 0);
    add_pixel(1, 0, 0);
    add_pixel(0, 1, 0);
    add_pixel(0, 0, 1);
    add_pixel(200, 100, 100);
    add_pixel(100, 200, 100);
    add_pixel(100, 100, 200);
    add_pixel(10, 20, 30);
    add_pixel(30, 20, 10);
    add_pixel(255, 254, 0);
    add_pixel(1, 1, 0);
    add_pixel(254, 255, 255);
    add_pixel(1, 1, 1);
    directed_cnt = pixel_q.size();
    // Random pixels: mostly uniform, with a share of greys, two-channel ties
    // and very dark pixels where the divisors are smallest.
    for (int n = 0; n < RAND_PIXELS; n++) begin
      r = $urandom_range(255);
      g = $urandom_range(255);
      b = $urandom_range(255);
      case ($urandom_range(9))
        0: begin
          g = r;
          b = r;
        end
        1: begin
          case ($urandom_range(2))
            0: g = r;
            1: b = r;
            default: b = g;
          endcase
        end
        2: begin
          r = $urandom_range(3);
          g = $urandom_range(3);
          b = $urandom_range(3);
        end
        default: ;
      endcase
      add_pixel(r, g, b);
    end
    total_pixels = pixel_q.size();

    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    while (pixel_q.size() != 0 || s_valid) @(posedge clk_i);
    while (hsv_owed_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (error_cnt == 0 && hsv_owed_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of this stimulus.
  initial begin
    #1000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

/* rgb_to_hsv_converter_unit.f */
hw/rtl/rthc_pkg.sv
hw/rtl/rthc_prep.sv
hw/rtl/rthc_div.sv
hw/rtl/rgb_to_hsv_converter_unit.sv
test/tb_rgb_to_hsv_converter_unit.sv
